FILE: rtl/rsod_pkg.sv
package rsod_pkg;

  localparam int DIST_W = 16;
  localparam int ANG_W  = 12;
  localparam int CTR_W  = 13;
  localparam int MINW_W = 12;
  localparam int STEP_W = 4;
  localparam int ASTART_W = 8;

  localparam int MAX_POINTS_DEFAULT = 128;

  localparam logic [1:0] KIND_OBJECT = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [2:0] REG_JUMP_LIMIT      = 3'd0;
  localparam logic [2:0] REG_MIN_WIDTH       = 3'd1;
  localparam logic [2:0] REG_ANGLE_START     = 3'd2;
  localparam logic [2:0] REG_ANGLE_STEP      = 3'd3;
  localparam logic [2:0] REG_APPROACH_OFFSET = 3'd4;

  localparam logic [DIST_W-1:0]   JUMP_LIMIT_RST      = 16'd4000;
  localparam logic [MINW_W-1:0]   MIN_WIDTH_RST       = 12'd6;
  localparam logic [ASTART_W-1:0] ANGLE_START_RST     = 8'd0;
  localparam logic [STEP_W-1:0]   ANGLE_STEP_RST      = 4'd2;
  localparam logic [DIST_W-1:0]   APPROACH_OFFSET_RST = 16'd1000;

  // straight ahead, in half degrees
  localparam logic [CTR_W-1:0] NONE_CENTER = 13'd180;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ANG_W-1:0]  start_angle;
    logic [ANG_W-1:0]  end_angle;
    logic [CTR_W-1:0]  center_half_degrees;
    logic [ANG_W-1:0]  angular_width;
    logic [DIST_W-1:0] object_distance;
    logic              run_last;
  } result_t;

  typedef struct packed {
    logic [DIST_W-1:0] prev_filtered;
    logic              on_object;
    logic [ANG_W-1:0]  start_angle;
    logic [DIST_W-1:0] running_min;
    logic              best_found;
    logic [ANG_W-1:0]  best_width;
    logic [CTR_W-1:0]  best_center;
    logic [DIST_W-1:0] best_distance;
  } track_t;

  localparam track_t TRACK_RESET = '{
    prev_filtered: '0,
    on_object:     1'b0,
    start_angle:   '0,
    running_min:   '1,
    best_found:    1'b0,
    best_width:    '1,
    best_center:   '0,
    best_distance: '0
  };

  typedef struct packed {
    track_t  st;
    logic    emit;
    result_t rec;
  } step_t;

  function automatic logic [DIST_W-1:0] med3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  function automatic step_t close_object(input track_t st,
                                         input logic [ANG_W-1:0] ea,
                                         input logic [MINW_W-1:0] min_width,
                                         input logic [DIST_W-1:0] offset);
    step_t r;
    logic [ANG_W-1:0] w;
    logic [CTR_W-1:0] c;
    r = '0;
    r.st = st;
    r.st.on_object = 1'b0;
    w = ea - st.start_angle;
    c = {1'b0, st.start_angle} + {1'b0, ea};
    r.emit = (w >= min_width);
    r.rec.kind = KIND_OBJECT;
    r.rec.start_angle = st.start_angle;
    r.rec.end_angle = ea;
    r.rec.center_half_degrees = c;
    r.rec.angular_width = w;
    r.rec.object_distance = st.running_min;
    r.rec.run_last = 1'b0;
    // first object wins on equal width
    if (r.emit && (!st.best_found || (w < st.best_width))) begin
      r.st.best_found = 1'b1;
      r.st.best_width = w;
      r.st.best_center = c;
      r.st.best_distance = (st.running_min > offset) ? (st.running_min - offset) : '0;
    end
    return r;
  endfunction

  function automatic step_t process_sample(input track_t st,
                                           input logic diff_en,
                                           input logic [DIST_W-1:0] f,
                                           input logic [ANG_W-1:0] angle,
                                           input logic [DIST_W-1:0] thr,
                                           input logic [MINW_W-1:0] min_width,
                                           input logic [DIST_W-1:0] offset);
    step_t r;
    logic [DIST_W:0] f_up;
    logic [DIST_W:0] prev_up;
    r = '0;
    r.st = st;
    f_up = {1'b0, f} + {1'b0, thr};
    prev_up = {1'b0, st.prev_filtered} + {1'b0, thr};
    if (diff_en) begin
      // falling edge: prev - f > thr, rising edge: f - prev > thr
      if (!st.on_object && ({1'b0, st.prev_filtered} > f_up)) begin
        r.st.on_object = 1'b1;
        r.st.start_angle = angle;
        r.st.running_min = f;
      end else if (st.on_object) begin
        if (f < st.running_min) begin
          r.st.running_min = f;
        end
        if ({1'b0, f} > prev_up) begin
          r = close_object(r.st, angle, min_width, offset);
        end
      end
    end
    r.st.prev_filtered = f;
    return r;
  endfunction

endpackage

FILE: rtl/range_sweep_object_detector_core.sv
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  sample_distance, sample_last
// out      output     out_valid/out_stall kind, start_angle, end_angle, center_half_degrees,
//                                        angular_width, object_distance, run_last
// cfg      input      apb write/read     jump_limit, min_width, angle_start, angle_step,
//                                        approach_offset
//
// one sample per cycle: input register filters, tracking register does edge and object logic
// a result enters the result queue as the tracking stage takes the transaction resolving it
// in_stall rises once two results wait in the 4-entry result queue; the last sample of a
// sweep can push three results and then holds in_stall while it drains
// synchronous reset returns all sweep state and the registers to their reset values
module range_sweep_object_detector_core
  import rsod_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DIST_W-1:0]   sample_distance,
  input  logic                sample_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [ANG_W-1:0]    start_angle,
  output logic [ANG_W-1:0]    end_angle,
  output logic [CTR_W-1:0]    center_half_degrees,
  output logic [ANG_W-1:0]    angular_width,
  output logic [DIST_W-1:0]   object_distance,
  output logic                run_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;

  // configuration
  logic [DIST_W-1:0]   jump_limit;
  logic [MINW_W-1:0]   min_width;
  logic [ASTART_W-1:0] angle_start;
  logic [STEP_W-1:0]   angle_step;
  logic [DIST_W-1:0]   approach_offset;
  logic                cfg_write;
  logic [2:0]          cfg_index;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit      <= JUMP_LIMIT_RST;
      min_width       <= MIN_WIDTH_RST;
      angle_start     <= ANGLE_START_RST;
      angle_step      <= ANGLE_STEP_RST;
      approach_offset <= APPROACH_OFFSET_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_JUMP_LIMIT:      jump_limit      <= pwdata[DIST_W-1:0];
        REG_MIN_WIDTH:       min_width       <= pwdata[MINW_W-1:0];
        REG_ANGLE_START:     angle_start     <= pwdata[ASTART_W-1:0];
        REG_ANGLE_STEP:      angle_step      <= pwdata[STEP_W-1:0];
        REG_APPROACH_OFFSET: approach_offset <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_JUMP_LIMIT:      prdata = 32'(jump_limit);
      REG_MIN_WIDTH:       prdata = 32'(min_width);
      REG_ANGLE_START:     prdata = 32'(angle_start);
      REG_ANGLE_STEP:      prdata = 32'(angle_step);
      REG_APPROACH_OFFSET: prdata = 32'(approach_offset);
      default:             prdata = '0;
    endcase
  end

  // input side: raw history and sample counter
  logic [DIST_W-1:0] raw_older;
  logic [DIST_W-1:0] raw_newer;
  logic [IDX_W-1:0]  sample_index;
  logic [IDX_W-1:0]  prev_index;
  logic              in_accept;
  logic              in_last;
  logic [DIST_W-1:0] in_filtered;
  logic [ANG_W-1:0]  in_angle_cur;
  logic [ANG_W-1:0]  in_angle_prev;

  // filter stage register
  logic              a_valid;
  logic              a_has_prev;
  logic              a_prev_diff;
  logic              a_cur_diff;
  logic              a_last;
  logic [DIST_W-1:0] a_filtered;
  logic [DIST_W-1:0] a_distance;
  logic [ANG_W-1:0]  a_angle_prev;
  logic [ANG_W-1:0]  a_angle_cur;
  logic              go;

  // result queue
  result_t           q [QDEPTH];
  result_t           q_next [QDEPTH];
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QCNT_W-1:0] count_pop;
  logic [QCNT_W-1:0] pos1;
  logic [QCNT_W-1:0] pos2;
  logic              pop;

  assign in_stall  = a_valid && !go;
  assign in_accept = in_valid && !in_stall;

  assign in_last = sample_last || (sample_index >= IDX_W'(MAX_POINTS - 1));
  assign prev_index = sample_index - IDX_W'(1);
  assign in_filtered = (sample_index == IDX_W'(1)) ? raw_newer
                     : med3(raw_older, raw_newer, sample_distance);
  assign in_angle_cur = ANG_W'(angle_start) + ANG_W'(sample_index) * ANG_W'(angle_step);
  assign in_angle_prev = ANG_W'(angle_start) + ANG_W'(prev_index) * ANG_W'(angle_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_older    <= '0;
      raw_newer    <= '0;
      sample_index <= '0;
    end else if (in_accept) begin
      if (in_last) begin
        raw_older    <= '0;
        raw_newer    <= '0;
        sample_index <= '0;
      end else begin
        raw_older    <= raw_newer;
        raw_newer    <= sample_distance;
        sample_index <= sample_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_has_prev   <= (sample_index != '0);
      a_prev_diff  <= (sample_index > IDX_W'(1));
      a_cur_diff   <= (sample_index != '0);
      a_last       <= in_last;
      a_filtered   <= in_filtered;
      a_distance   <= sample_distance;
      a_angle_prev <= in_angle_prev;
      a_angle_cur  <= in_angle_cur;
    end
  end

  // tracking stage
  track_t  track;
  step_t   step1;
  step_t   step2;
  step_t   forced;
  track_t  fin;
  result_t r0;
  result_t r1;
  result_t r2;
  logic    v0;
  logic    v1;
  logic    v2;
  logic [CTR_W:0] fin_sum;

  always_comb begin
    if (a_has_prev) begin
      step1 = process_sample(track, a_prev_diff, a_filtered, a_angle_prev,
                             jump_limit, min_width, approach_offset);
    end else begin
      step1 = '0;
      step1.st = track;
    end
    step2 = process_sample(step1.st, a_cur_diff, a_distance, a_angle_cur,
                           jump_limit, min_width, approach_offset);
    // object still open at sweep end closes at the last sample
    forced = close_object(step2.st, a_angle_cur, min_width, approach_offset);

    r0 = step1.rec;
    v0 = step1.emit;
    if (step2.st.on_object) begin
      fin = forced.st;
      r1 = forced.rec;
      v1 = a_last && forced.emit;
    end else begin
      fin = step2.st;
      r1 = step2.rec;
      v1 = a_last && step2.emit;
    end

    v2 = a_last;
    fin_sum = {1'b0, fin.best_center} + (CTR_W + 1)'(fin.best_width);
    r2 = '0;
    r2.run_last = 1'b1;
    if (fin.best_found) begin
      r2.kind = KIND_TARGET;
      r2.start_angle = (fin.best_center >= CTR_W'(fin.best_width))
                     ? ANG_W'((fin.best_center - CTR_W'(fin.best_width)) >> 1) : '0;
      r2.end_angle = fin_sum[ANG_W:1];
      r2.center_half_degrees = fin.best_center;
      r2.angular_width = fin.best_width;
      r2.object_distance = fin.best_distance;
    end else begin
      r2.kind = KIND_NONE;
      r2.center_half_degrees = NONE_CENTER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track <= TRACK_RESET;
    end else if (go) begin
      track <= a_last ? TRACK_RESET : step1.st;
    end
  end

  // queue takes a transaction only with room for the worst case of three results
  assign go = a_valid && (count <= QCNT_W'(QDEPTH - 3));
  assign pop = out_valid && !out_stall;
  assign count_pop = count - QCNT_W'(pop);
  assign pos1 = count_pop + QCNT_W'(v0);
  assign pos2 = pos1 + QCNT_W'(v1);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_next[i] = q[(i < QDEPTH - 1) ? i + 1 : i];
      end else begin
        q_next[i] = q[i];
      end
      if (go) begin
        if (v0 && (QCNT_W'(i) == count_pop)) begin
          q_next[i] = r0;
        end
        if (v1 && (QCNT_W'(i) == pos1)) begin
          q_next[i] = r1;
        end
        if (v2 && (QCNT_W'(i) == pos2)) begin
          q_next[i] = r2;
        end
      end
    end
    count_next = go ? pos2 + QCNT_W'(v2) : count_pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign out_valid           = (count != '0);
  assign kind                = q[0].kind;
  assign start_angle         = q[0].start_angle;
  assign end_angle           = q[0].end_angle;
  assign center_half_degrees = q[0].center_half_degrees;
  assign angular_width       = q[0].angular_width;
  assign object_distance     = q[0].object_distance;
  assign run_last            = q[0].run_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue over capacity");

  a_sweep_end_clears: assert property (@(posedge clk) disable iff (rst)
    (go && a_last) |=> (!track.on_object && !track.best_found))
    else $error("tracking state not cleared after sweep end");

  a_sweep_end_result: assert property (@(posedge clk) disable iff (rst)
    (go && a_last) |=> (count != '0))
    else $error("sweep end produced no result");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && (count > QCNT_W'(QDEPTH - 3))))
    else $error("input stalled without a full queue");
`endif

endmodule
